### rtl/core/mlsh_pkg.sv
// Package for the multi-level sensor history block: ring geometry, codes,
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mlsh_pkg;

    localparam int MINUTE_DEPTH = 12;
    localparam int HOUR_DEPTH   = 60;
    localparam int DAY_DEPTH    = 96;
    localparam int MONTH_DEPTH  = 56;
    localparam int YEAR_DEPTH   = 52;
    localparam int LEVELS       = 5;

    localparam int TOTAL_DEPTH = MINUTE_DEPTH + HOUR_DEPTH + DAY_DEPTH
                               + MONTH_DEPTH + YEAR_DEPTH;
    localparam int MAX_DEPTH_A = (MINUTE_DEPTH > HOUR_DEPTH) ? MINUTE_DEPTH : HOUR_DEPTH;
    localparam int MAX_DEPTH_B = (DAY_DEPTH > MONTH_DEPTH) ? DAY_DEPTH : MONTH_DEPTH;
    localparam int MAX_DEPTH_C = (MAX_DEPTH_A > MAX_DEPTH_B) ? MAX_DEPTH_A : MAX_DEPTH_B;
    localparam int MAX_DEPTH   = (MAX_DEPTH_C > YEAR_DEPTH) ? MAX_DEPTH_C : YEAR_DEPTH;

    localparam int IDX_W = $clog2(MAX_DEPTH);
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int AW    = $clog2(TOTAL_DEPTH);
    localparam int SUM_W = 16 + CNT_W;
    localparam int NUM_W = 32;
    localparam int DEN_W = 24;

    localparam logic [15:0] MISSING = 16'h8000;

    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] CFG_HOUR_PERIOD  = 3'd0;
    localparam logic [2:0] CFG_DAY_PERIOD   = 3'd1;
    localparam logic [2:0] CFG_MONTH_PERIOD = 3'd2;
    localparam logic [2:0] CFG_YEAR_PERIOD  = 3'd3;
    localparam logic [2:0] CFG_HOUR_WINDOW  = 3'd4;
    localparam logic [2:0] CFG_DAY_WINDOW   = 3'd5;
    localparam logic [2:0] CFG_MONTH_WINDOW = 3'd6;

    localparam logic [1:0] LAST_STEP = 2'd3;

    typedef struct packed {
        logic       cap;        // latch input item
        logic       clr_start;  // restart clearing sweep
        logic       clr_step;   // write one cleared entry
        logic       push0;      // store sample in minute ring
        logic       mod_start;  // counter modulo period of level step
        logic       mean_arch;  // set up walk for archive step
        logic       mean_qry;   // set up walk for query
        logic       acc;        // accumulate read entry
        logic       div_mean;   // start mean division
        logic       push_mean;  // store mean in next coarser ring
        logic       set_qry;    // query result from mean
        logic       load_out;   // move result to output register
        logic [1:0] step;       // archive step: 0 hour .. 3 year
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       div_done;
        logic       due;
        logic       walk_done;
        logic       cnt_zero;
        logic       lvl_ok;
        logic       out_free;
        logic [1:0] op;
    } t_sts;

    function automatic logic [CNT_W-1:0] depth_of(input logic [2:0] lvl);
        logic [CNT_W-1:0] d;
        case (lvl)
            3'd0:    d = CNT_W'(MINUTE_DEPTH);
            3'd1:    d = CNT_W'(HOUR_DEPTH);
            3'd2:    d = CNT_W'(DAY_DEPTH);
            3'd3:    d = CNT_W'(MONTH_DEPTH);
            default: d = CNT_W'(YEAR_DEPTH);
        endcase
        return d;
    endfunction

    function automatic logic [AW-1:0] base_of(input logic [2:0] lvl);
        logic [AW-1:0] b;
        case (lvl)
            3'd0:    b = '0;
            3'd1:    b = AW'(MINUTE_DEPTH);
            3'd2:    b = AW'(MINUTE_DEPTH + HOUR_DEPTH);
            3'd3:    b = AW'(MINUTE_DEPTH + HOUR_DEPTH + DAY_DEPTH);
            default: b = AW'(MINUTE_DEPTH + HOUR_DEPTH + DAY_DEPTH + MONTH_DEPTH);
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

### rtl/core/mlsh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mlsh_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/core/mlsh_div.sv
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// Depends on mlsh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlsh_div
    import mlsh_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic      [NUM_W-1:0] o_quo,
    output logic      [DEN_W-1:0] o_rem
);

    localparam int ITER_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [ITER_W-1:0] r_iter;
    logic              r_busy;

    logic [DEN_W:0] n_trial;
    logic [DEN_W:0] n_diff;
    logic           n_ge;

    always_comb begin
        n_trial = {r_rem, r_quo[NUM_W-1]};
        n_ge    = n_trial >= {1'b0, r_den};
        n_diff  = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= ITER_W'(NUM_W);
            r_quo  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= n_ge ? n_diff[DEN_W-1:0] : n_trial[DEN_W-1:0];
            r_quo  <= {r_quo[NUM_W-2:0], n_ge};
            r_iter <= r_iter - 1'b1;
            if (r_iter == ITER_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

### rtl/core/mlsh_dp.sv
// Datapath: configuration registers, sample counter, ring heads, ring memory,
// ring walk accumulator, shared divider and output register.
// Depends on mlsh_pkg, mlsh_ram, mlsh_div.
`timescale 1ns / 1ps
`default_nettype none
module mlsh_dp
    import mlsh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic        i_cfg_valid,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_sample,
    input  wire logic [2:0]  i_level,
    input  wire logic [6:0]  i_count,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic      [15:0] o_value,
    output logic             o_valid,
    output logic      [3:0]  o_arch
);

    // configuration
    logic [11:0] r_hour_period;
    logic [15:0] r_day_period;
    logic [19:0] r_month_period;
    logic [23:0] r_year_period;
    logic [3:0]  r_hour_window;
    logic [5:0]  r_day_window;
    logic [6:0]  r_month_window;

    // captured item
    logic [1:0]  r_op;
    logic [15:0] r_sample;
    logic [2:0]  r_level;
    logic [6:0]  r_count;

    logic [31:0]      r_counter;
    logic [IDX_W-1:0] r_head [LEVELS];
    logic [AW-1:0]    r_clr;

    // ring walk
    logic [2:0]             r_lvl;
    logic [CNT_W-1:0]       r_n;
    logic [CNT_W-1:0]       r_k;
    logic [IDX_W-1:0]       r_idx;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_neg;
    logic [DEN_W-1:0]       r_per;

    // pending result and output register
    logic [15:0] r_res_value;
    logic        r_res_valid;
    logic [3:0]  r_res_arch;
    logic        r_out_valid;
    logic [15:0] r_out_value;
    logic        r_out_res_valid;
    logic [3:0]  r_out_arch;

    logic [15:0]      rd_data;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [15:0]      wdata;
    logic [AW-1:0]    raddr;

    logic             div_busy;
    logic [NUM_W-1:0] div_quo;
    logic [DEN_W-1:0] div_rem;
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;

    logic [2:0]       push_lvl;
    logic [IDX_W-1:0] push_head;
    logic [CNT_W-1:0] push_depth;
    logic [CNT_W:0]   head_inc;
    logic [IDX_W-1:0] new_head;

    logic [2:0]       arch_ring;
    logic [CNT_W-1:0] arch_win;
    logic [CNT_W-1:0] arch_n;
    logic [CNT_W-1:0] qry_depth;
    logic [CNT_W-1:0] qry_n;
    logic [DEN_W-1:0] per_sel;
    logic [SUM_W-1:0] sum_mag;
    logic [15:0]      mean_mag;
    logic [15:0]      mean_val;
    logic [CNT_W-1:0] walk_depth;
    logic             out_free;

    // -------- selection logic
    always_comb begin
        push_lvl   = i_cmd.push0 ? 3'd0 : ({1'b0, i_cmd.step} + 3'd1);
        push_head  = r_head[push_lvl];
        push_depth = depth_of(push_lvl);
        head_inc   = {1'b0, CNT_W'(push_head)} + 1'b1;
        new_head   = (head_inc >= {1'b0, push_depth}) ? '0 : push_head + 1'b1;

        arch_ring = {1'b0, i_cmd.step};
        case (i_cmd.step)
            2'd0:    arch_win = CNT_W'(r_hour_window);
            2'd1:    arch_win = CNT_W'(r_day_window);
            2'd2:    arch_win = CNT_W'(r_month_window);
            default: arch_win = CNT_W'(MONTH_DEPTH);
        endcase
        arch_n = (arch_win > depth_of(arch_ring)) ? depth_of(arch_ring) : arch_win;

        qry_depth = depth_of(r_level);
        qry_n     = (CNT_W'(r_count) > qry_depth) ? qry_depth : CNT_W'(r_count);

        case (i_cmd.step)
            2'd0:    per_sel = DEN_W'(r_hour_period);
            2'd1:    per_sel = DEN_W'(r_day_period);
            2'd2:    per_sel = DEN_W'(r_month_period);
            default: per_sel = r_year_period;
        endcase

        sum_mag  = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
        mean_mag = div_quo[15:0];
        mean_val = (r_cnt == '0) ? MISSING : (r_neg ? (~mean_mag + 1'b1) : mean_mag);

        walk_depth = depth_of(r_lvl);
        raddr      = base_of(r_lvl) + AW'(r_idx);

        we    = 1'b0;
        waddr = r_clr;
        wdata = MISSING;
        if (i_cmd.clr_step) begin
            we = 1'b1;
        end else if (i_cmd.push0) begin
            we    = 1'b1;
            waddr = base_of(push_lvl) + AW'(new_head);
            wdata = r_sample;
        end else if (i_cmd.push_mean) begin
            we    = 1'b1;
            waddr = base_of(push_lvl) + AW'(new_head);
            wdata = mean_val;
        end

        div_start = i_cmd.mod_start | i_cmd.div_mean;
        div_num   = i_cmd.mod_start ? r_counter : {{(NUM_W-SUM_W){1'b0}}, sum_mag};
        div_den   = i_cmd.mod_start ? per_sel : DEN_W'(r_cnt);

        out_free = !r_out_valid || i_out_ready;
    end

    mlsh_ram #(
        .DEPTH (TOTAL_DEPTH),
        .WIDTH (16)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    mlsh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // -------- configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_period  <= 12'd12;
            r_day_period   <= 16'd180;
            r_month_period <= 20'd8640;
            r_year_period  <= 24'd120960;
            r_hour_window  <= 4'd12;
            r_day_window   <= 6'd15;
            r_month_window <= 7'd48;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HOUR_PERIOD:  r_hour_period  <= i_cfg_data[11:0];
                CFG_DAY_PERIOD:   r_day_period   <= i_cfg_data[15:0];
                CFG_MONTH_PERIOD: r_month_period <= i_cfg_data[19:0];
                CFG_YEAR_PERIOD:  r_year_period  <= i_cfg_data;
                CFG_HOUR_WINDOW:  r_hour_window  <= i_cfg_data[3:0];
                CFG_DAY_WINDOW:   r_day_window   <= i_cfg_data[5:0];
                CFG_MONTH_WINDOW: r_month_window <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // -------- control state: counter, heads, clear sweep, output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter   <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= IDX_W'(depth_of(3'(l)) - 1'b1);
            end
        end else begin
            if (i_cmd.clr_start) begin
                r_clr <= '0;
                for (int l = 0; l < LEVELS; l++) begin
                    r_head[l] <= IDX_W'(depth_of(3'(l)) - 1'b1);
                end
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.push0 || i_cmd.push_mean) begin
                r_head[push_lvl] <= new_head;
            end
            if (i_cmd.push0) begin
                r_counter <= r_counter + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // -------- payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op        <= i_op;
            r_sample    <= i_sample;
            r_level     <= i_level;
            r_count     <= i_count;
            r_res_value <= MISSING;
            r_res_valid <= 1'b0;
            r_res_arch  <= '0;
        end
        if (i_cmd.push0) begin
            r_res_value <= r_sample;
            r_res_valid <= r_sample != MISSING;
        end
        if (i_cmd.push_mean) begin
            r_res_arch[i_cmd.step] <= 1'b1;
        end
        if (i_cmd.set_qry) begin
            r_res_value <= mean_val;
            r_res_valid <= r_cnt != '0;
        end
        if (i_cmd.mod_start) begin
            r_per <= per_sel;
        end
        if (i_cmd.mean_arch || i_cmd.mean_qry) begin
            r_lvl <= i_cmd.mean_arch ? arch_ring : r_level;
            r_n   <= i_cmd.mean_arch ? arch_n : qry_n;
            r_idx <= r_head[i_cmd.mean_arch ? arch_ring : r_level];
            r_k   <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.acc) begin
            if (rd_data != MISSING) begin
                r_sum <= r_sum + {{(SUM_W-16){rd_data[15]}}, rd_data};
                r_cnt <= r_cnt + 1'b1;
            end
            r_k   <= r_k + 1'b1;
            r_idx <= (r_idx == '0) ? IDX_W'(walk_depth - 1'b1) : r_idx - 1'b1;
        end
        if (i_cmd.div_mean) begin
            r_neg <= r_sum[SUM_W-1];
        end
        if (i_cmd.load_out) begin
            r_out_value     <= r_res_value;
            r_out_res_valid <= r_res_valid;
            r_out_arch      <= r_res_arch;
        end
    end

    always_comb begin
        o_sts.clr_last  = r_clr == AW'(TOTAL_DEPTH - 1);
        o_sts.div_done  = !div_busy;
        o_sts.due       = (r_per != '0) && (r_counter >= {8'd0, r_per})
                          && (div_rem == '0);
        o_sts.walk_done = r_k == r_n;
        o_sts.cnt_zero  = r_cnt == '0;
        o_sts.lvl_ok    = r_level < 3'(LEVELS);
        o_sts.out_free  = out_free;
        o_sts.op        = r_op;
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_valid     = r_out_res_valid;
    assign o_arch      = r_out_arch;

endmodule
`default_nettype wire

### rtl/core/mlsh_ctrl.sv
// Controller state machine: sequences clearing, store, archive steps and
// queries by issuing commands to the datapath.
// Depends on mlsh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlsh_ctrl
    import mlsh_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DISP, S_PUSH0, S_MOD, S_MODW,
        S_RD, S_ACC, S_DIVW, S_FIN, S_NEXT, S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;
    logic       r_clr_op, n_clr_op;

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_clr_op = r_clr_op;
        o_cmd      = '0;
        o_cmd.step = r_step;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_clr_op ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.op)
                    OP_STORE: n_state = S_PUSH0;
                    OP_QUERY: begin
                        if (i_sts.lvl_ok) begin
                            o_cmd.mean_qry = 1'b1;
                            n_state        = S_RD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clr_start = 1'b1;
                        n_clr_op        = 1'b1;
                        n_state         = S_CLR;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_PUSH0: begin
                o_cmd.push0 = 1'b1;
                n_step      = '0;
                n_state     = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod_start = 1'b1;
                n_state         = S_MODW;
            end
            S_MODW: begin
                if (i_sts.div_done) begin
                    if (i_sts.due) begin
                        o_cmd.mean_arch = 1'b1;
                        n_state         = S_RD;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_RD: begin
                if (i_sts.walk_done) begin
                    if (i_sts.cnt_zero) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.div_mean = 1'b1;
                        n_state        = S_DIVW;
                    end
                end else begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_RD;
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.op == OP_QUERY) begin
                    o_cmd.set_qry = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.push_mean = 1'b1;
                    n_state         = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = S_MOD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_clr_op       = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_step     <= '0;
            r_clr_op   <= 1'b0;
            o_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_clr_op   <= n_clr_op;
            o_in_ready <= n_state == S_IDLE;
        end
    end

endmodule
`default_nettype wire

### rtl/core/multi_level_sensor_history.sv
// Top level of the multi-level sensor history block.
// Depends on mlsh_pkg, mlsh_ctrl, mlsh_dp.
//
// Five cascaded ring archives (minute 12, hour 60, day 96, month 56, year 52
// entries) held in one 276-entry RAM. One item at a time: a store writes the
// sample, bumps the sample counter and, for each of hour, day, month and year
// in that order, tests counter mod period on a bit-serial divider and, when
// due, walks the finer ring, reading and then accumulating each entry, and
// divides the sum by the valid count before writing the new entry. After
// reset a clearing pass runs with s_axis_tready low; configuration writes
// are taken at any time but only while idle they are meaningful. A result
// waits in an output register, so the next item is taken while it is unread.
`timescale 1ns / 1ps
`default_nettype none
module multi_level_sensor_history
    import mlsh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // sample[15:0], level[18:16], count[25:19]
    input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,  // result_value[15:0], archived_levels[19:16]
    output logic      [0:0]  m_axis_tuser   // result_valid[0]
);

    t_cmd        cmd;
    t_sts        sts;
    logic [15:0] res_value;
    logic        res_valid;
    logic [3:0]  res_arch;

    // registers are plain flops, always writable
    assign o_cfg_ready = 1'b1;

    mlsh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mlsh_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_axis_tuser),
        .i_sample    (s_axis_tdata[15:0]),
        .i_level     (s_axis_tdata[18:16]),
        .i_count     (s_axis_tdata[25:19]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_value     (res_value),
        .o_valid     (res_valid),
        .o_arch      (res_arch)
    );

    assign m_axis_tdata = {4'd0, res_arch, res_value};
    assign m_axis_tuser = res_valid;

endmodule
`default_nettype wire
